// ===== rtl/qass_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qass_pkg;

   // character codes the spacer looks at
   localparam logic [7:0] CharSpace     = 8'h20;
   localparam logic [7:0] CharDollar    = 8'h24;
   localparam logic [7:0] CharBackslash = 8'h5C;
   localparam logic [7:0] CharDquote    = 8'h22;
   localparam logic [7:0] CharSquote    = 8'h27;
   localparam logic [7:0] CharLt        = 8'h3C;
   localparam logic [7:0] CharGt        = 8'h3E;
   localparam logic [7:0] CharPipe      = 8'h7C;
   localparam logic [7:0] CharSemi      = 8'h3B;
   localparam logic [7:0] SpecialDollar = 8'd220;

   // most bytes one input character can expand to
   localparam int unsigned MaxRun = 4;
   localparam int unsigned RunIdxW = $clog2(MaxRun);

   typedef enum logic [1:0] {
      QuoteNone   = 2'd0,
      QuoteDouble = 2'd1,
      QuoteSingle = 2'd2
   } quote_mode_type;

   // one decoded character: its output bytes and line-end flags
   typedef struct packed {
      logic [MaxRun-1:0][7:0] bytes;
      logic [RunIdxW-1:0]     last_idx;
      logic                   eol;
      logic                   qerr;
   } run_type;

   function automatic logic is_separator(input logic [7:0] c);
      is_separator = (c == CharLt) || (c == CharGt) || (c == CharPipe) || (c == CharSemi);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/qass_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface qass_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_line;

   modport source (output valid, output in_byte, output end_of_line, input ready);
   modport sink   (input valid, input in_byte, input end_of_line, output ready);
endinterface

`default_nettype wire

// ===== rtl/qass_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface qass_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       line_done;
   logic       quote_error;

   modport source (output valid, output out_byte, output run_last, output line_done,
                   output quote_error, input ready);
   modport sink   (input valid, input out_byte, input run_last, input line_done,
                   input quote_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/quote_aware_separator_spacer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                                      Handshake
// req_ch   in   in_byte[7:0], end_of_line                    valid/ready
// rsp_ch   out  out_byte[7:0], run_last, line_done,          valid/ready
//               quote_error
//
// One character per cycle when each expands to one byte and rsp_ch is ready;
// a character that expands to n bytes (up to 4) holds the run buffer until all n have transferred.
// The first byte passes the input register and then the run buffer before it
// is offered on rsp_ch.
// The input register can hold one character while the run buffer is stalled.
// Synchronous active-high reset clears valid flags and the quote/escape state.

module quote_aware_separator_spacer (
   input  wire logic  clock,
   input  wire logic  reset,
   qass_req_if.sink   req_ch,
   qass_rsp_if.source rsp_ch
);

   logic [7:0]        byte_ff;
   logic              eol_ff;
   logic              in_valid_ff;
   logic              can_load;
   logic              advance;
   qass_pkg::run_type run;

   assign advance      = in_valid_ff && can_load;
   assign req_ch.ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         byte_ff <= req_ch.in_byte;
         eol_ff  <= req_ch.end_of_line;
      end
   end

   qass_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_byte     (byte_ff),
      .end_of_line (eol_ff),
      .run         (run)
   );

   qass_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .run      (run),
      .load     (advance),
      .can_load (can_load),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== rtl/qass_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qass_decode (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire logic [7:0]       in_byte,
   input  wire logic             end_of_line,
   output qass_pkg::run_type     run
);

   qass_pkg::quote_mode_type quote_ff, quote_in;
   logic bslash_ff, bslash_in;
   logic pend_ff, pend_in;

   logic joined;
   logic esc;
   logic dollar;
   logic sep;
   logic [qass_pkg::RunIdxW-1:0] base;

   assign joined = pend_ff && (in_byte == qass_pkg::CharGt);
   assign esc    = bslash_ff;
   assign dollar = (in_byte == qass_pkg::CharDollar) && (quote_ff != qass_pkg::QuoteSingle)
                   && !esc;
   assign sep    = (quote_ff == qass_pkg::QuoteNone) && !esc && qass_pkg::is_separator(in_byte);
   assign base   = pend_ff ? qass_pkg::RunIdxW'(1) : qass_pkg::RunIdxW'(0);

   // next quote state; escaped quotes and a joined '>' leave it alone
   always_comb begin
      quote_in = quote_ff;
      if (!joined && !esc) begin
         unique case (quote_ff)
            qass_pkg::QuoteNone: begin
               if (in_byte == qass_pkg::CharDquote) quote_in = qass_pkg::QuoteDouble;
               else if (in_byte == qass_pkg::CharSquote) quote_in = qass_pkg::QuoteSingle;
            end
            qass_pkg::QuoteDouble: begin
               if (in_byte == qass_pkg::CharDquote) quote_in = qass_pkg::QuoteNone;
            end
            qass_pkg::QuoteSingle: begin
               if (in_byte == qass_pkg::CharSquote) quote_in = qass_pkg::QuoteNone;
            end
            default: quote_in = quote_ff;
         endcase
      end
   end

   // output run; unwritten slots stay as spaces
   always_comb begin
      run.bytes    = {qass_pkg::MaxRun{qass_pkg::CharSpace}};
      run.last_idx = base;
      run.eol      = end_of_line;
      run.qerr     = (quote_in != qass_pkg::QuoteNone);
      if (joined) begin
         run.bytes[0] = qass_pkg::CharGt;
         run.last_idx = qass_pkg::RunIdxW'(1);
      end else if (dollar) begin
         run.bytes[base] = qass_pkg::SpecialDollar;
      end else if (sep) begin
         run.bytes[base + qass_pkg::RunIdxW'(1)] = in_byte;
         run.last_idx = base + (end_of_line ? qass_pkg::RunIdxW'(2) : qass_pkg::RunIdxW'(1));
      end else begin
         run.bytes[base] = in_byte;
      end
   end

   // line state for the following character
   always_comb begin
      bslash_in = joined ? 1'b0 : (in_byte == qass_pkg::CharBackslash);
      pend_in   = !joined && sep && !end_of_line;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quote_ff  <= qass_pkg::QuoteNone;
         bslash_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else if (advance) begin
         if (end_of_line) begin
            quote_ff  <= qass_pkg::QuoteNone;
            bslash_ff <= 1'b0;
            pend_ff   <= 1'b0;
         end else begin
            quote_ff  <= quote_in;
            bslash_ff <= bslash_in;
            pend_ff   <= pend_in;
         end
      end
   end

   // a separator only waits when it was unquoted and unescaped
   a_pend_clean: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (quote_ff == qass_pkg::QuoteNone) && !bslash_ff)
      else $error("separator pending inside quotes or after backslash");

endmodule

`default_nettype wire

// ===== rtl/qass_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qass_emit (
   input  wire logic          clock,
   input  wire logic          reset,
   input  qass_pkg::run_type  run,
   input  wire logic          load,
   output logic               can_load,
   qass_rsp_if.source         rsp_ch
);

   qass_pkg::run_type            run_ff;
   logic [qass_pkg::RunIdxW-1:0] idx_ff;
   logic                         valid_ff;
   logic                         at_last;
   logic                         xfer;

   assign at_last  = (idx_ff == run_ff.last_idx);
   assign xfer     = valid_ff && rsp_ch.ready;
   assign can_load = !valid_ff || (xfer && at_last);

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.out_byte    = run_ff.bytes[idx_ff];
   assign rsp_ch.run_last    = at_last;
   assign rsp_ch.line_done   = at_last && run_ff.eol;
   assign rsp_ch.quote_error = at_last && run_ff.eol && run_ff.qerr;

   // run buffer: one byte leaves per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (xfer && at_last) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         run_ff <= run;
         idx_ff <= '0;
      end else if (xfer && !at_last) begin
         idx_ff <= idx_ff + qass_pkg::RunIdxW'(1);
      end
   end

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> idx_ff <= run_ff.last_idx)
      else $error("run index beyond last byte");

   a_qerr_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.quote_error |-> rsp_ch.line_done && rsp_ch.run_last)
      else $error("quote error flagged away from line end");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (xfer && at_last && !load) |=> !valid_ff)
      else $error("run buffer not emptied after last byte");

endmodule

`default_nettype wire

// ===== tb/tb_quote_aware_separator_spacer.sv =====
`timescale 1ns / 1ps

module tb_quote_aware_separator_spacer;

   localparam int TotalItems  = 500;
   localparam int CycleLimit  = 200000;
   localparam int SettleTime  = 20;
   localparam int LongHold    = 300;
   localparam int PrintLimit  = 40;

   // one character offered to the spacer
   typedef struct {
      logic [7:0] ch;
      logic       eol;
      logic       wait_drain;
   } line_char_type;

   // one spaced output byte with its flags
   typedef struct {
      logic [7:0] out_byte;
      logic       run_last;
      logic       line_done;
      logic       quote_error;
   } out_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qass_req_if req_if ();
   qass_rsp_if rsp_if ();

   quote_aware_separator_spacer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always #5 clock = ~clock;

   line_char_type  pending_chars [$];
   out_char_type   awaited_chars [$];
   int             mismatch_count = 0;
   int             cycle_count = 0;

   // spacer state as the predictor sees it
   qass_pkg::quote_mode_type quote_state = qass_pkg::QuoteNone;
   logic           after_backslash = 1'b0;
   logic           owes_space = 1'b0;

   // ------------------------------------------------------------------
   // Predictor: expands one accepted character into its spaced bytes
   // ------------------------------------------------------------------
   function automatic void space_char(input logic [7:0] c, input logic eol);
      logic [7:0]   run [$];
      logic         joined;
      logic         esc;
      out_char_type rec;
      joined = 1'b0;

      // a separator still owes its trailing space; a '>' joins it first
      if (owes_space) begin
         owes_space = 1'b0;
         if (c == qass_pkg::CharGt) begin
            run.push_back(c);
            run.push_back(qass_pkg::CharSpace);
            after_backslash = 1'b0;
            joined = 1'b1;
         end else begin
            run.push_back(qass_pkg::CharSpace);
         end
      end

      if (!joined) begin
         esc = after_backslash;
         if (c == qass_pkg::CharDollar && quote_state != qass_pkg::QuoteSingle && !esc) begin
            run.push_back(qass_pkg::SpecialDollar);
         end else if (quote_state == qass_pkg::QuoteNone && !esc &&
                      (c == qass_pkg::CharLt || c == qass_pkg::CharGt ||
                       c == qass_pkg::CharPipe || c == qass_pkg::CharSemi)) begin
            run.push_back(qass_pkg::CharSpace);
            run.push_back(c);
            if (eol) run.push_back(qass_pkg::CharSpace);
            else     owes_space = 1'b1;
         end else begin
            run.push_back(c);
         end

         // quote tracking uses the mode before this byte
         if (!esc) begin
            case (quote_state)
               qass_pkg::QuoteNone: begin
                  if (c == qass_pkg::CharDquote)      quote_state = qass_pkg::QuoteDouble;
                  else if (c == qass_pkg::CharSquote) quote_state = qass_pkg::QuoteSingle;
               end
               qass_pkg::QuoteDouble: begin
                  if (c == qass_pkg::CharDquote) quote_state = qass_pkg::QuoteNone;
               end
               qass_pkg::QuoteSingle: begin
                  if (c == qass_pkg::CharSquote) quote_state = qass_pkg::QuoteNone;
               end
               default: ;
            endcase
         end
         after_backslash = (c == qass_pkg::CharBackslash);
      end

      foreach (run[i]) begin
         rec.out_byte    = run[i];
         rec.run_last    = (i == run.size() - 1);
         rec.line_done   = eol && rec.run_last;
         rec.quote_error = rec.line_done && (quote_state != qass_pkg::QuoteNone);
         awaited_chars.push_back(rec);
      end

      // a new line starts from reset state
      if (eol) begin
         quote_state     = qass_pkg::QuoteNone;
         after_backslash = 1'b0;
         owes_space      = 1'b0;
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= PrintLimit)
         $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic push_char(input logic [7:0] ch, input logic eol, input logic drain);
      line_char_type item;
      item.ch         = ch;
      item.eol        = eol;
      item.wait_drain = drain;
      pending_chars.push_back(item);
   endtask

   task automatic push_line(input string s, input logic drain);
      for (int i = 0; i < s.len(); i++)
         push_char(s[i], i == s.len() - 1, drain && i == 0);
   endtask

   // weighted mix: plain text, separators, quotes, escapes, dollars, any byte
   function automatic logic [7:0] pick_char();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 30)      return 8'($urandom_range(8'h20, 8'h7E));
      else if (sel < 40) return qass_pkg::CharGt;
      else if (sel < 50) begin
         case ($urandom_range(0, 2))
            0:       return qass_pkg::CharLt;
            1:       return qass_pkg::CharPipe;
            default: return qass_pkg::CharSemi;
         endcase
      end
      else if (sel < 58) return qass_pkg::CharDquote;
      else if (sel < 66) return qass_pkg::CharSquote;
      else if (sel < 75) return qass_pkg::CharBackslash;
      else if (sel < 85) return qass_pkg::CharDollar;
      else if (sel < 88) return qass_pkg::CharSpace;
      else               return 8'($urandom_range(0, 255));
   endfunction

   // ------------------------------------------------------------------
   // Driver: bursts of transfers with random gaps
   // ------------------------------------------------------------------
   int   burst_left = 0;
   int   gap_left = 0;
   logic drv_offer;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid       <= 1'b0;
         req_if.in_byte     <= '0;
         req_if.end_of_line <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!(req_if.valid && !req_if.ready)) begin
         // a transfer completed at this edge
         if (req_if.valid) begin
            space_char(pending_chars[0].ch, pending_chars[0].eol);
            pending_chars.pop_front();
         end
         drv_offer = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_chars.size() != 0 &&
                      !(pending_chars[0].wait_drain && awaited_chars.size() != 0)) begin
            drv_offer = 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end
         req_if.valid <= drv_offer;
         if (drv_offer) begin
            req_if.in_byte     <= pending_chars[0].ch;
            req_if.end_of_line <= pending_chars[0].eol;
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: stall pattern in phases, plus long hold-offs
   // ------------------------------------------------------------------
   int   rx_mode = 0;
   int   rx_phase_left = 0;
   int   long_hold_left = 0;
   int   rsp_seen = 0;
   logic rx_take;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_seen++;
            if (rsp_seen == 120 || rsp_seen == 600) long_hold_left = LongHold;
         end
         if (rx_phase_left == 0) begin
            rx_mode       = $urandom_range(0, 2);
            rx_phase_left = $urandom_range(10, 80);
         end else begin
            rx_phase_left--;
         end
         if (long_hold_left > 0) begin
            long_hold_left--;
            rx_take = 1'b0;
         end else begin
            case (rx_mode)
               0:       rx_take = 1'b1;
               1:       rx_take = $urandom_range(0, 1);
               default: rx_take = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_if.ready <= rx_take;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: compare each result transfer with the oldest expectation
   // ------------------------------------------------------------------
   out_char_type want;

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_chars.size() == 0) begin
            report_mismatch("unexpected result, out_byte", int'(rsp_if.out_byte), -1);
         end else begin
            want = awaited_chars.pop_front();
            if (rsp_if.out_byte !== want.out_byte)
               report_mismatch("out_byte", int'(rsp_if.out_byte), int'(want.out_byte));
            if (rsp_if.run_last !== want.run_last)
               report_mismatch("run_last", int'(rsp_if.run_last), int'(want.run_last));
            if (rsp_if.line_done !== want.line_done)
               report_mismatch("line_done", int'(rsp_if.line_done), int'(want.line_done));
            if (rsp_if.quote_error !== want.quote_error)
               report_mismatch("quote_error", int'(rsp_if.quote_error),
                               int'(want.quote_error));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("quote_aware_separator_spacer: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      int len;

      // directed: zero and all-ones bytes, dollar, joined '>', pending
      // separator followed by another byte, separator on the last byte
      push_char(8'h00, 1'b0, 1'b0);
      push_char(8'hFF, 1'b0, 1'b0);
      push_line("$<>|x;", 1'b0);
      // escaped quote, dollar in double quotes, escaped backslash, open quote
      push_line("\\\"\"$>\\\\\"", 1'b0);
      // single quotes: literal dollar and pipe, backslash does not close
      push_line("'$|\\'a", 1'b0);
      // lone separator, after the sender has waited for every result
      push_line(">", 1'b1);
      // separator joined by '>' on the last byte
      push_line("|>", 1'b0);
      // escaped separator
      push_line("\\<>", 1'b0);

      // random lines, mostly short
      while (pending_chars.size() < TotalItems) begin
         len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(13, 30);
         for (int i = 0; i < len; i++)
            push_char(pick_char(), i == len - 1, i == 0 && $urandom_range(0, 19) == 0);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_chars.size() != 0 || req_if.valid || awaited_chars.size() != 0)
         @(negedge clock);
      repeat (SettleTime) @(negedge clock);

      if (mismatch_count == 0)
         $display("quote_aware_separator_spacer: match");
      else
         $display("quote_aware_separator_spacer: mismatch");
      $finish;
   end

endmodule
